// File: sv/nps_pkg.sv
// Shared types, widths and state codes for the non-preemptive priority scheduler.
package nps_pkg;

    // Default number of job slots.
    localparam int MAX_JOBS_DEF = 16;

    // Field widths fixed by the interface.
    localparam int ARR_W       = 16;
    localparam int BURST_W     = 16;
    localparam int PRIO_W      = 8;
    localparam int JOB_INDEX_W = 4;
    localparam int OUT_TIME_W  = 21;

    // One stored job record.
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } job_rec_t;

    // Scheduler sequencer states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PICK,
        ST_EMIT
    } nps_state_t;

endpackage

// File: sv/nps_job_mem.sv
// Job record store: one write port, one read port with registered read data.
module nps_job_mem
    import nps_pkg::*;
#(
    parameter  int DEPTH = MAX_JOBS_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  job_rec_t      wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output job_rec_t      rdata
);

    job_rec_t mem [DEPTH];
    job_rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/nonpreemptive_priority_scheduler.sv
// Top level of the non-preemptive priority scheduler: loader, scan sequencer and result register.
//
//   Channel  Handshake                    Payload
//   job      job_valid / job_ready        arrival_time, burst_time, job_priority, is_last
//   result   result_valid / result_ready  job_index, start_time, completion_time,
//                                         turnaround_time, waiting_time, last_result
//
// Loading takes one job record per cycle; records are written into the job memory.
// After the record that carries is_last, each scheduled job costs one scan of the
// stored jobs through the single read port of the job memory, plus one more scan
// when the clock must first jump ahead to the earliest pending arrival; the result
// is then posted from the emit state.
// Reset clears the job count, the done flags, the clock and all handshake state.
// A stalled result holds the sequencer in its emit state; job_ready is low from the
// closing record until the last result of the batch has moved into the output register.
module nonpreemptive_priority_scheduler
    import nps_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   job_valid,
    output logic                   job_ready,
    input  logic [ARR_W-1:0]       arrival_time,
    input  logic [BURST_W-1:0]     burst_time,
    input  logic [PRIO_W-1:0]      job_priority,
    input  logic                   is_last,

    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [JOB_INDEX_W-1:0] job_index,
    output logic [OUT_TIME_W-1:0]  start_time,
    output logic [OUT_TIME_W-1:0]  completion_time,
    output logic [OUT_TIME_W-1:0]  turnaround_time,
    output logic [OUT_TIME_W-1:0]  waiting_time,
    output logic                   last_result
);

    // Slot index and count widths.
    localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    // The clock never exceeds the largest arrival plus all bursts, which is below
    // 2^16 * (MAX_JOBS + 1), so this width holds every time value without loss.
    localparam int TIME_W = ARR_W + CNT_W;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_JOBS);

    // Sequencer and control registers.
    nps_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic [MAX_JOBS-1:0] done_reg, done_next;
    logic [TIME_W-1:0] cur_reg, cur_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              found_reg, found_next;
    logic              result_valid_reg, result_valid_next;

    // Scan pipeline and best-candidate payload registers.
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              rd_last_reg, rd_last_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    job_rec_t          best_reg, best_next;
    logic [ARR_W-1:0]  earliest_reg, earliest_next;

    // Output payload registers.
    logic [JOB_INDEX_W-1:0] job_index_reg, job_index_next;
    logic [OUT_TIME_W-1:0]  start_reg, start_next;
    logic [OUT_TIME_W-1:0]  comp_reg, comp_next;
    logic [OUT_TIME_W-1:0]  tat_reg, tat_next;
    logic [OUT_TIME_W-1:0]  wait_reg, wait_next;
    logic                   last_reg, last_next;

    // Memory port signals and sequencer strobes.
    logic       job_xfer;
    logic       mem_we;
    logic       mem_re;
    logic       emit_go;
    job_rec_t   wr_rec;
    job_rec_t   rd_rec;

    // Candidate evaluation on the entry that just came out of memory.
    logic              cand_pend;
    logic              cand_ready;
    logic              cand_better;
    logic [TIME_W-1:0] comp_time;
    logic [TIME_W-1:0] wait_time;
    logic [TIME_W-1:0] tat_time;

    assign wr_rec.arrival = arrival_time;
    assign wr_rec.burst   = burst_time;
    assign wr_rec.prio    = job_priority;

    nps_job_mem #(
        .DEPTH (MAX_JOBS)
    ) u_job_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_rec),
        .re    (mem_re),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (rd_rec)
    );

    // A job is a candidate when it is unfinished; it is ready when it has arrived.
    // Strict compares keep the lower index on a full tie, since the scan runs upward.
    assign cand_pend   = rd_valid_reg && !done_reg[rd_idx_reg];
    assign cand_ready  = cand_pend && (TIME_W'(rd_rec.arrival) <= cur_reg);
    assign cand_better = !found_reg
                         || (rd_rec.prio < best_reg.prio)
                         || ((rd_rec.prio == best_reg.prio)
                             && (rd_rec.arrival < best_reg.arrival));

    // Result arithmetic for the selected job; it started once it had arrived.
    assign comp_time = cur_reg + TIME_W'(best_reg.burst);
    assign wait_time = cur_reg - TIME_W'(best_reg.arrival);
    assign tat_time  = comp_time - TIME_W'(best_reg.arrival);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (job_xfer && is_last && (count_next != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_valid_reg && rd_last_reg)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = found_reg ? ST_EMIT : ST_SCAN;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = (remain_reg == CNT_ONE) ? ST_LOAD : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        job_ready = 1'b0;
        mem_re    = 1'b0;
        emit_go   = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                job_ready = 1'b1;
            end
            ST_SCAN:
            begin
                mem_re = (issue_reg < count_reg);
            end
            ST_PICK:
            begin
                emit_go = 1'b0;
            end
            ST_EMIT:
            begin
                emit_go = !result_valid_reg || result_ready;
            end
            default:
            begin
                job_ready = 1'b0;
            end
        endcase
    end

    assign job_xfer = job_valid && job_ready;
    // Records past capacity are dropped, but their is_last flag still closes the batch.
    assign mem_we   = job_xfer && (count_reg < CNT_FULL);

    // Datapath next values.
    always_comb
    begin
        count_next        = count_reg;
        remain_next       = remain_reg;
        issue_next        = issue_reg;
        done_next         = done_reg;
        cur_next          = cur_reg;
        found_next        = found_reg;
        best_idx_next     = best_idx_reg;
        best_next         = best_reg;
        earliest_next     = earliest_reg;
        rd_valid_next     = mem_re;
        rd_idx_next       = issue_reg[IDX_W-1:0];
        rd_last_next      = (issue_reg == (count_reg - CNT_ONE));
        job_index_next    = job_index_reg;
        start_next        = start_reg;
        comp_next         = comp_reg;
        tat_next          = tat_reg;
        wait_next         = wait_reg;
        last_next         = last_reg;
        result_valid_next = result_valid_reg && !result_ready;

        if (mem_we)
        begin
            count_next = count_reg + CNT_ONE;
        end

        if (mem_re)
        begin
            issue_next = issue_reg + CNT_ONE;
        end

        // Fold the entry read last cycle into the running best and earliest arrival.
        if (cand_pend && (rd_rec.arrival < earliest_reg))
        begin
            earliest_next = rd_rec.arrival;
        end
        if (cand_ready && cand_better)
        begin
            found_next    = 1'b1;
            best_idx_next = rd_idx_reg;
            best_next     = rd_rec;
        end

        // Closing the batch arms the first scan.
        if ((state_reg == ST_LOAD) && job_xfer && is_last)
        begin
            remain_next   = count_next;
            issue_next    = '0;
            found_next    = 1'b0;
            earliest_next = '1;
        end

        // Nothing has arrived yet: move the clock to the earliest pending job and rescan.
        if ((state_reg == ST_PICK) && !found_reg)
        begin
            cur_next      = TIME_W'(earliest_reg);
            issue_next    = '0;
            earliest_next = '1;
        end

        if (emit_go)
        begin
            job_index_next    = JOB_INDEX_W'(best_idx_reg);
            start_next        = OUT_TIME_W'(cur_reg);
            comp_next         = OUT_TIME_W'(comp_time);
            tat_next          = OUT_TIME_W'(tat_time);
            wait_next         = OUT_TIME_W'(wait_time);
            last_next         = (remain_reg == CNT_ONE);
            result_valid_next = 1'b1;

            remain_next             = remain_reg - CNT_ONE;
            done_next[best_idx_reg] = 1'b1;
            cur_next                = comp_time;
            issue_next              = '0;
            found_next              = 1'b0;
            earliest_next           = '1;

            // The final job of the batch returns the scheduler to an empty batch.
            if (remain_reg == CNT_ONE)
            begin
                count_next = '0;
                done_next  = '0;
                cur_next   = '0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            remain_reg       <= '0;
            issue_reg        <= '0;
            done_reg         <= '0;
            cur_reg          <= '0;
            rd_valid_reg     <= 1'b0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            remain_reg       <= remain_next;
            issue_reg        <= issue_next;
            done_reg         <= done_next;
            cur_reg          <= cur_next;
            rd_valid_reg     <= rd_valid_next;
            found_reg        <= found_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        rd_last_reg   <= rd_last_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        earliest_reg  <= earliest_next;
        job_index_reg <= job_index_next;
        start_reg     <= start_next;
        comp_reg      <= comp_next;
        tat_reg       <= tat_next;
        wait_reg      <= wait_next;
        last_reg      <= last_next;
    end

    assign result_valid    = result_valid_reg;
    assign job_index       = job_index_reg;
    assign start_time      = start_reg;
    assign completion_time = comp_reg;
    assign turnaround_time = tat_reg;
    assign waiting_time    = wait_reg;
    assign last_result     = last_reg;

endmodule
